// ===== design/rhwf_pkg.sv =====
// ----------------------------------------------------------------------------
// rhwf_pkg
// types, codes and helpers shared by the right-hand wall follower
// ----------------------------------------------------------------------------
package rhwf_pkg;

	localparam int RHWF_MAX_GRID = 32;
	localparam int RHWF_CFG_W    = 6;
	localparam int RHWF_CFG_IW   = 2;

	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_RESTART = 2'd1;
	localparam logic [1:0] KIND_STEP    = 2'd2;

	localparam logic [1:0] HD_UP    = 2'd0;
	localparam logic [1:0] HD_RIGHT = 2'd1;
	localparam logic [1:0] HD_DOWN  = 2'd2;
	localparam logic [1:0] HD_LEFT  = 2'd3;

	localparam logic [RHWF_CFG_IW-1:0] CFG_GRID_SIZE     = 2'd0;
	localparam logic [RHWF_CFG_IW-1:0] CFG_START_X       = 2'd1;
	localparam logic [RHWF_CFG_IW-1:0] CFG_START_Y       = 2'd2;
	localparam logic [RHWF_CFG_IW-1:0] CFG_START_HEADING = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic       cell_wall;
	} rhwf_req_t;

	typedef struct packed {
		logic [4:0] pos_x;
		logic [4:0] pos_y;
		logic [1:0] heading;
		logic       moved;
		logic       done_res;
		logic       trapped;
	} rhwf_rsp_t;

	// neighbouring cell; off marks a step past the 0..31 coordinate range
	typedef struct packed {
		logic       off;
		logic [4:0] x;
		logic [4:0] y;
	} rhwf_nb_t;

	function automatic rhwf_nb_t rhwf_neighbour(input logic [4:0] x, input logic [4:0] y,
			input logic [1:0] h);
		rhwf_nb_t nb;
		nb.off = 1'b0;
		nb.x   = x;
		nb.y   = y;
		case (h)
			HD_UP: begin
				nb.off = (y == 5'd0);
				nb.y   = y - 5'd1;
			end
			HD_RIGHT: begin
				nb.off = (x == 5'd31);
				nb.x   = x + 5'd1;
			end
			HD_DOWN: begin
				nb.off = (y == 5'd31);
				nb.y   = y + 5'd1;
			end
			default: begin
				nb.off = (x == 5'd0);
				nb.x   = x - 5'd1;
			end
		endcase
		return nb;
	endfunction

endpackage

// ===== design/right_hand_wall_follower.sv =====
// ----------------------------------------------------------------------------
// right_hand_wall_follower
// walks a loaded wall grid by the right-hand rule, at most one cell per step item
//
//   channel   signals                       payload
//   req       req_valid / req_ready         req  (rhwf_req_t)
//   rsp       rsp_valid / rsp_ready         rsp  (rhwf_rsp_t)
//   cfg       cfg_we                        cfg_index, cfg_data
//
// cell write, restart and steps that need no grid look go from accept straight to the result state
// a walking step makes one grid look per heading tried through the single ram read
//   port (up to four looks) between accept and result
// the grid ram and result payload are not reset; walker state, config and rsp_valid are
// a result sits in the output register while the next item is taken; the
//   item after that waits until the output register is free
// ----------------------------------------------------------------------------
module right_hand_wall_follower
	import rhwf_pkg::*;
#(
	parameter int MAX_GRID = RHWF_MAX_GRID
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  rhwf_req_t              req,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output rhwf_rsp_t              rsp,
	input  logic                   cfg_we,
	input  logic [RHWF_CFG_IW-1:0] cfg_index,
	input  logic [RHWF_CFG_W-1:0]  cfg_data
);

	localparam int DEPTH = MAX_GRID * MAX_GRID;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_EMIT = 3'b100
	} rhwf_state_t;

	rhwf_state_t state_q;

	logic [5:0] grid_size_q;
	logic [4:0] start_x_q, start_y_q;
	logic [1:0] start_heading_q;

	logic [4:0] x_q, y_q;
	logic [1:0] heading_q;
	logic       first_q, finished_q, stuck_q, moved_q;
	logic [1:0] look_q;
	rhwf_nb_t   nb_q;
	logic       nb_oob_q;

	rhwf_rsp_t  rsp_q;
	logic       rsp_valid_q;

	logic [5:0] size_use;
	logic [1:0] rd_heading;
	rhwf_nb_t   rd_nb, first_nb;
	logic       rd_oob;
	logic [AW-1:0] raddr, waddr;
	logic       wr_en, rd_wall, accept;
	logic       grid_rdata;

	function automatic logic interior(input logic [4:0] x, input logic [4:0] y,
			input logic [5:0] s);
		return (x != 5'd0) && ({1'b0, x} < s - 6'd1) && (y != 5'd0) && ({1'b0, y} < s - 6'd1);
	endfunction

	// size in use, saturated to 3..32 and to the store
	always_comb begin
		size_use = grid_size_q;
		if (grid_size_q < 6'd3) begin
			size_use = 6'd3;
		end else if (grid_size_q > 6'd32) begin
			size_use = 6'd32;
		end
		if (int'(size_use) > MAX_GRID) begin
			size_use = 6'(MAX_GRID);
		end
	end

	assign accept     = req_valid && req_ready;
	assign req_ready  = (state_q == ST_IDLE);
	assign rd_heading = (state_q == ST_LOOK) ? heading_q - 2'd1 : heading_q + 2'd1;
	assign rd_nb      = rhwf_neighbour(x_q, y_q, rd_heading);
	assign rd_oob     = rd_nb.off || int'(rd_nb.x) >= MAX_GRID || int'(rd_nb.y) >= MAX_GRID;
	assign first_nb   = rhwf_neighbour(x_q, y_q, heading_q);
	assign raddr      = AW'(AW'(rd_nb.y) * AW'(MAX_GRID) + AW'(rd_nb.x));
	assign waddr      = AW'(AW'(req.cell_y) * AW'(MAX_GRID) + AW'(req.cell_x));
	assign wr_en      = accept && req.kind == KIND_WRITE
		&& int'(req.cell_x) < MAX_GRID && int'(req.cell_y) < MAX_GRID;
	assign rd_wall    = nb_oob_q || grid_rdata;

	rhwf_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(req.cell_wall),
		.raddr(raddr),
		.rdata(grid_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q     <= 6'd19;
			start_x_q       <= 5'd18;
			start_y_q       <= 5'd17;
			start_heading_q <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_SIZE:     grid_size_q     <= cfg_data;
				CFG_START_X:       start_x_q       <= cfg_data[4:0];
				CFG_START_Y:       start_y_q       <= cfg_data[4:0];
				CFG_START_HEADING: start_heading_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// walker sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			x_q        <= '0;
			y_q        <= '0;
			heading_q  <= HD_UP;
			first_q    <= 1'b0;
			finished_q <= 1'b1;
			stuck_q    <= 1'b0;
			moved_q    <= 1'b0;
			look_q     <= '0;
			nb_q       <= '0;
			nb_oob_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						moved_q <= 1'b0;
						state_q <= ST_EMIT;
						if (req.kind == KIND_RESTART) begin
							x_q        <= start_x_q;
							y_q        <= start_y_q;
							heading_q  <= start_heading_q;
							first_q    <= 1'b1;
							finished_q <= 1'b0;
							stuck_q    <= 1'b0;
						end else if (req.kind == KIND_STEP && !finished_q && !stuck_q) begin
							if (first_q) begin
								first_q <= 1'b0;
								if (first_nb.off) begin
									finished_q <= 1'b1;
								end else begin
									x_q     <= first_nb.x;
									y_q     <= first_nb.y;
									moved_q <= 1'b1;
									if (!interior(first_nb.x, first_nb.y, size_use)) begin
										finished_q <= 1'b1;
									end
								end
							end else if (!interior(x_q, y_q, size_use)) begin
								finished_q <= 1'b1;
							end else begin
								heading_q <= rd_heading;
								look_q    <= '0;
								nb_q      <= rd_nb;
								nb_oob_q  <= rd_oob;
								state_q   <= ST_LOOK;
							end
						end
					end
				end
				ST_LOOK: begin
					if (!rd_wall) begin
						x_q     <= nb_q.x;
						y_q     <= nb_q.y;
						moved_q <= 1'b1;
						if (!interior(nb_q.x, nb_q.y, size_use)) begin
							finished_q <= 1'b1;
						end
						state_q <= ST_EMIT;
					end else begin
						heading_q <= rd_heading;
						look_q    <= look_q + 2'd1;
						nb_q      <= rd_nb;
						nb_oob_q  <= rd_oob;
						if (look_q == 2'd3) begin
							stuck_q <= 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.pos_x    <= x_q;
			rsp_q.pos_y    <= y_q;
			rsp_q.heading  <= heading_q;
			rsp_q.moved    <= moved_q;
			rsp_q.done_res <= finished_q && !stuck_q;
			rsp_q.trapped  <= stuck_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	ast_trap_after_four_looks: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stuck_q) |-> $past(state_q == ST_LOOK && look_q == 2'd3))
		else $error("trapped without four wall looks");

	ast_look_only_when_walking: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK |-> !finished_q && !stuck_q && !first_q)
		else $error("grid look outside an active walk");

	ast_rsp_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.trapped && (rsp.done_res || rsp.moved)))
		else $error("trapped result also reports done or move");
`endif

endmodule

// ===== design/rhwf_ram.sv =====
// ----------------------------------------------------------------------------
// rhwf_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module rhwf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
